>>> sv/sdf_pkg.sv
package sdf_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // configuration registers are unsigned Q.FRAC with one bit less than a word
    localparam int REG_BITS      = 31;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STIFFNESS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DAMPING   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REST      = 2'd2;

    // reset values as whole numbers, scaled by the fraction bits at the top level
    localparam int STIFF_RESET_INT = 640;
    localparam int DAMP_RESET_INT  = 13;
    localparam int REST_RESET_INT  = 1;

endpackage

>>> sv/sdf_sqrt.sv
module sdf_sqrt #(
    parameter int WORD_BITS = sdf_pkg::WORD_BITS_DEF,
    parameter int SIDE_BITS = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2*WORD_BITS-1:0] i_rad,
    input  logic [SIDE_BITS-1:0]   i_side,
    output logic                   o_valid,
    output logic [WORD_BITS-1:0]   o_root,
    output logic [SIDE_BITS-1:0]   o_side
);
    import sdf_pkg::*;

    localparam int XW = 2 * WORD_BITS;

    logic [XW-1:0]        r_x   [WORD_BITS];
    logic [XW-1:0]        r_res [WORD_BITS];
    logic [XW-1:0]        n_x   [WORD_BITS];
    logic [XW-1:0]        n_res [WORD_BITS];
    logic [SIDE_BITS-1:0] r_side[WORD_BITS];
    logic [WORD_BITS-1:0] r_v;

    // one result bit per stage, radicand consumed two bits at a time
    always_comb begin
        logic [XW-1:0] x_in;
        logic [XW-1:0] res_in;
        logic [XW-1:0] one_pos;
        logic [XW-1:0] trial;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (k == 0) begin
                x_in   = i_rad;
                res_in = '0;
            end else begin
                x_in   = r_x[k-1];
                res_in = r_res[k-1];
            end
            one_pos = {{(XW-1){1'b0}}, 1'b1} << (2 * (WORD_BITS - 1 - k));
            trial   = res_in + one_pos;
            if (x_in >= trial) begin
                n_x[k]   = x_in - trial;
                n_res[k] = (res_in >> 1) + one_pos;
            end else begin
                n_x[k]   = x_in;
                n_res[k] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[WORD_BITS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < WORD_BITS; k++) begin
                r_x[k]   <= n_x[k];
                r_res[k] <= n_res[k];
                if (k == 0) begin
                    r_side[k] <= i_side;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[WORD_BITS-1];
    assign o_root  = r_res[WORD_BITS-1][WORD_BITS-1:0];
    assign o_side  = r_side[WORD_BITS-1];

endmodule

>>> sv/sdf_div.sv
module sdf_div #(
    parameter int WORD_BITS = sdf_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF,
    parameter int SIDE_BITS = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [3*WORD_BITS-1:0]     i_num,
    input  logic [WORD_BITS-1:0]       i_den,
    input  logic [SIDE_BITS-1:0]       i_side,
    output logic                       o_valid,
    output logic [3*(FRAC_BITS+2)-1:0] o_quot,
    output logic [WORD_BITS-1:0]       o_den,
    output logic [SIDE_BITS-1:0]       o_side
);
    import sdf_pkg::*;

    localparam int RW = WORD_BITS + FRAC_BITS;
    localparam int NS = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;

    logic [RW-1:0]        r_rem [NS][3];
    logic [RW-1:0]        n_rem [NS][3];
    logic [FRAC_BITS:0]   r_q   [NS][3];
    logic [FRAC_BITS:0]   n_q   [NS][3];
    logic [2:0]           r_neg [NS];
    logic [WORD_BITS-1:0] r_den [NS];
    logic [SIDE_BITS-1:0] r_side[NS];
    logic [NS-1:0]        r_v;
    logic [RW-1:0]        init_rem[3];
    logic [2:0]           init_neg;

    always_comb begin
        logic [WORD_BITS-1:0] num;
        logic [WORD_BITS-1:0] mag;
        for (int l = 0; l < 3; l++) begin
            num         = i_num[l*WORD_BITS +: WORD_BITS];
            init_neg[l] = num[WORD_BITS-1];
            mag         = num[WORD_BITS-1] ? (~num + 1'b1) : num;
            init_rem[l] = {mag, {FRAC_BITS{1'b0}}};
        end
    end

    // quotient is at most one in Q.FRAC, so FRAC_BITS+1 restoring steps suffice
    always_comb begin
        logic [WORD_BITS-1:0] den_in;
        logic [RW-1:0]        rem_in;
        logic [FRAC_BITS:0]   q_in;
        logic [RW:0]          dsh;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                den_in = i_den;
            end else begin
                den_in = r_den[k-1];
            end
            dsh = {{(FRAC_BITS+1){1'b0}}, den_in} << (FRAC_BITS - k);
            for (int l = 0; l < 3; l++) begin
                if (k == 0) begin
                    rem_in = init_rem[l];
                    q_in   = '0;
                end else begin
                    rem_in = r_rem[k-1][l];
                    q_in   = r_q[k-1][l];
                end
                if ({1'b0, rem_in} >= dsh) begin
                    n_rem[k][l] = rem_in - dsh[RW-1:0];
                    n_q[k][l]   = q_in | ({{FRAC_BITS{1'b0}}, 1'b1} << (FRAC_BITS - k));
                end else begin
                    n_rem[k][l] = rem_in;
                    n_q[k][l]   = q_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_q[k][l]   <= n_q[k][l];
                end
                if (k == 0) begin
                    r_neg[k]  <= init_neg;
                    r_den[k]  <= i_den;
                    r_side[k] <= i_side;
                end else begin
                    r_neg[k]  <= r_neg[k-1];
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    always_comb begin
        logic [QW-1:0] q;
        for (int l = 0; l < 3; l++) begin
            q = {1'b0, r_q[NS-1][l]};
            o_quot[l*QW +: QW] = r_neg[NS-1][l] ? (~q + 1'b1) : q;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_den   = r_den[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

>>> sv/spring_damper_force_core.sv
// Spring-damper force between two particles, pipelined.
// Input stream (i_s_*): tdata holds sep_x/y/z then relvel_x/y/z, signed Q.FRAC words;
// tuser holds first_pinned (bit 0) and second_pinned (bit 1).
// Output stream (o_m_*): tdata holds force_a_x/y/z then force_b_x/y/z; tuser holds
// zero_length (bit 0) and clipped (bit 1). One result per input transaction.
// Config channel (i_cfg_*): index 0 stiffness, 1 damping gain, 2 rest length, low 31
// bits of data used; o_cfg_ready is always high. Write only while the pipe is empty.
// The pipeline has one squaring stage, one square-root stage per result bit, one divider
// stage per quotient bit of the unit direction, then six arithmetic stages. Throughput is
// one transaction per cycle while i_m_tready is high or the output register is empty.
// Reset empties the pipeline and loads the default stiffness 640, damping 13 and
// rest length 1. A stall on i_m_tready freezes every stage at once and drops
// o_s_tready in the same cycle, so nothing is lost or repeated; bubbles in flight
// are held along with the data.
module spring_damper_force_core #(
    parameter int WORD_BITS = sdf_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF,
    localparam int TDW = ((6 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // sep_x, sep_y, sep_z, relvel_x, relvel_y, relvel_z (lowest first)
    input  logic [TDW-1:0]                   i_s_tdata,
    // first_pinned, second_pinned (lowest first)
    input  logic [1:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z (lowest first)
    output logic [TDW-1:0]                   o_m_tdata,
    // zero_length, clipped (lowest first)
    output logic [1:0]                       o_m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sdf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [sdf_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import sdf_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int EW  = F + 2;
    localparam int PW  = W + F + 2;
    localparam int DW  = W + F + 4;
    localparam int SPW = DW - F;
    localparam int SW  = ((W > REG_BITS) ? W : REG_BITS) + 2;
    localparam int CW  = W + F;
    localparam int TW  = REG_BITS + SW + SPW + CW;
    localparam int SQ_SIDE  = 6 * W + 2;
    localparam int DIV_SIDE = 3 * W + 3;

    localparam logic [CW-1:0] CAP     = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] POS_LIM = {{(F+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [CW-1:0] NEG_LIM = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic signed [EW-1:0] E_MAX = {2'b01, {F{1'b0}}};

    localparam logic [REG_BITS-1:0] K_RST = REG_BITS'(64'(STIFF_RESET_INT) << F);
    localparam logic [REG_BITS-1:0] C_RST = REG_BITS'(64'(DAMP_RESET_INT) << F);
    localparam logic [REG_BITS-1:0] L_RST = REG_BITS'(64'(REST_RESET_INT) << F);

    logic w_en;

    logic [REG_BITS-1:0] r_stiff, r_damp, r_rest;

    logic                r_s0_v;
    logic [2*W-1:0]      r_s0_sq;
    logic [SQ_SIDE-1:0]  r_s0_side;

    logic                sq_valid;
    logic [W-1:0]        sq_root;
    logic [SQ_SIDE-1:0]  sq_side;
    logic [DIV_SIDE-1:0] div_in_side;

    logic                div_valid;
    logic [3*EW-1:0]     div_quot;
    logic [W-1:0]        div_den;
    logic [DIV_SIDE-1:0] div_side;

    logic                    r_s1_v, r_s1_zero;
    logic [1:0]              r_s1_pin;
    logic signed [EW-1:0]    r_s1_e[3];
    logic signed [PW-1:0]    r_s1_prod[3];
    logic signed [SW-1:0]    r_s1_stretch;

    logic                    r_s2_v, r_s2_zero;
    logic [1:0]              r_s2_pin;
    logic signed [EW-1:0]    r_s2_e[3];
    logic signed [SPW-1:0]   r_s2_speed;
    logic signed [SW-1:0]    r_s2_stretch;

    logic                    r_s3_v, r_s3_zero, r_s3_hit;
    logic [1:0]              r_s3_pin;
    logic signed [EW-1:0]    r_s3_e[3];
    logic [CW-1:0]           r_s3_sp_mag, r_s3_dm_mag;
    logic                    r_s3_sp_neg, r_s3_dm_neg;

    logic                    r_s4_v, r_s4_zero, r_s4_capped, r_s4_fneg;
    logic [1:0]              r_s4_pin;
    logic signed [EW-1:0]    r_s4_e[3];
    logic [CW-1:0]           r_s4_fmag;

    logic                    r_s5_v, r_s5_zero, r_s5_capped;
    logic [1:0]              r_s5_pin;
    logic [CW-1:0]           r_s5_m[3];
    logic [2:0]              r_s5_rneg, r_s5_enz;

    logic                    r_s6_v;
    logic [TDW-1:0]          r_s6_data;
    logic [1:0]              r_s6_user;

    logic signed [PW-1:0]    n_s1_prod[3];
    logic signed [SW-1:0]    n_s1_stretch;
    logic signed [EW-1:0]    div_e[3];
    logic signed [SPW-1:0]   n_s2_speed;
    logic [CW-1:0]           n_s3_sp_mag, n_s3_dm_mag;
    logic                    n_s3_hit;
    logic [CW-1:0]           n_s4_fmag;
    logic                    n_s4_fneg, n_s4_over;
    logic [CW-1:0]           n_s5_m[3];
    logic [TDW-1:0]          n_s6_data;
    logic                    n_s6_clip;

    // returns {clip, word} for a magnitude and a sign
    function automatic logic [W:0] sat_word(input logic [CW-1:0] m, input logic neg);
        logic [W-1:0] v;
        logic         c;
        c = 1'b0;
        if (!neg) begin
            if (m > POS_LIM) begin
                c = 1'b1;
                v = {1'b0, {(W-1){1'b1}}};
            end else begin
                v = m[W-1:0];
            end
        end else begin
            if (m > NEG_LIM) begin
                c = 1'b1;
                v = {1'b1, {(W-1){1'b0}}};
            end else begin
                v = ~m[W-1:0] + 1'b1;
            end
        end
        return {c, v};
    endfunction

    assign w_en        = !r_s6_v || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= K_RST;
            r_damp  <= C_RST;
            r_rest  <= L_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STIFFNESS: r_stiff <= i_cfg_data[REG_BITS-1:0];
                CFG_DAMPING:   r_damp  <= i_cfg_data[REG_BITS-1:0];
                CFG_REST:      r_rest  <= i_cfg_data[REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // squared length
    always_ff @(posedge i_clk) begin
        logic [W-1:0]   d;
        logic [W-1:0]   mag;
        logic [2*W-1:0] acc;
        if (w_en) begin
            acc = '0;
            for (int i = 0; i < 3; i++) begin
                d   = i_s_tdata[i*W +: W];
                mag = d[W-1] ? (~d + 1'b1) : d;
                acc = acc + mag * mag;
            end
            r_s0_sq   <= acc;
            r_s0_side <= {i_s_tuser, i_s_tdata[6*W-1:0]};
        end
    end

    sdf_sqrt #(
        .WORD_BITS (W),
        .SIDE_BITS (SQ_SIDE)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_v),
        .i_rad   (r_s0_sq),
        .i_side  (r_s0_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign div_in_side = {(sq_root == '0), sq_side[6*W+1:6*W], sq_side[6*W-1:3*W]};

    sdf_div #(
        .WORD_BITS (W),
        .FRAC_BITS (F),
        .SIDE_BITS (DIV_SIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (sq_valid),
        .i_num   (sq_side[3*W-1:0]),
        .i_den   (sq_root),
        .i_side  (div_in_side),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_den   (div_den),
        .o_side  (div_side)
    );

    // stage 1: velocity projections and stretch
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_e[i]     = $signed(div_quot[i*EW +: EW]);
            n_s1_prod[i] = $signed(div_side[i*W +: W]) * div_e[i];
        end
        n_s1_stretch = $signed({{(SW-W){1'b0}}, div_den})
                     - $signed({{(SW-REG_BITS){1'b0}}, r_rest});
    end

    // stage 2: closing speed, truncated toward zero
    always_comb begin
        logic signed [DW-1:0] dot;
        dot = '0;
        for (int i = 0; i < 3; i++) begin
            dot = dot + DW'(r_s1_prod[i]);
        end
        if (dot[DW-1]) begin
            dot = dot + DW'({F{1'b1}});
        end
        n_s2_speed = dot[DW-1:F];
    end

    // stage 3: spring and damper terms, each magnitude capped
    always_comb begin
        logic [SW-1:0]           st_mag;
        logic [SPW-1:0]          sp_mag;
        logic [REG_BITS+SW-1:0]  p_sp;
        logic [REG_BITS+SPW-1:0] p_dm;
        logic [TW-1:0]           q_sp, q_dm;
        st_mag = r_s2_stretch[SW-1] ? (~r_s2_stretch + 1'b1) : r_s2_stretch;
        sp_mag = r_s2_speed[SPW-1] ? (~r_s2_speed + 1'b1) : r_s2_speed;
        p_sp   = r_stiff * st_mag;
        p_dm   = r_damp * sp_mag;
        q_sp   = TW'(p_sp >> F);
        q_dm   = TW'(p_dm >> F);
        n_s3_hit = 1'b0;
        if (q_sp > TW'(CAP)) begin
            n_s3_sp_mag = CAP;
            n_s3_hit    = 1'b1;
        end else begin
            n_s3_sp_mag = q_sp[CW-1:0];
        end
        if (q_dm > TW'(CAP)) begin
            n_s3_dm_mag = CAP;
            n_s3_hit    = 1'b1;
        end else begin
            n_s3_dm_mag = q_dm[CW-1:0];
        end
    end

    // stage 4: scalar force, negated and clamped
    always_comb begin
        logic signed [CW+1:0] t_sp, t_dm, sum;
        logic [CW+1:0]        smag;
        t_sp = $signed({2'b00, r_s3_sp_mag});
        t_dm = $signed({2'b00, r_s3_dm_mag});
        if (r_s3_sp_neg) t_sp = -t_sp;
        if (r_s3_dm_neg) t_dm = -t_dm;
        sum       = t_sp + t_dm;
        n_s4_fneg = !sum[CW+1] && (sum != '0);
        smag      = sum[CW+1] ? (~sum + 1'b1) : sum;
        n_s4_over = smag > {2'b00, CAP};
        n_s4_fmag = n_s4_over ? CAP : smag[CW-1:0];
    end

    // stage 5: force along the direction
    always_comb begin
        logic [F:0]      emag;
        logic [EW-1:0]   eabs;
        logic [CW+F:0]   pm;
        for (int i = 0; i < 3; i++) begin
            eabs      = r_s4_e[i][EW-1] ? (~r_s4_e[i] + 1'b1) : r_s4_e[i];
            emag      = eabs[F:0];
            pm        = r_s4_fmag * emag;
            n_s5_m[i] = pm[CW+F-1:F];
        end
    end

    // stage 6: saturate, apply pins and the zero-length case
    always_comb begin
        logic [W:0] sa, sb;
        n_s6_data = '0;
        n_s6_clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sa = sat_word(r_s5_m[i], r_s5_rneg[i]);
            sb = sat_word(r_s5_m[i], !r_s5_rneg[i]);
            if (!r_s5_pin[0]) begin
                n_s6_data[i*W +: W] = sa[W-1:0];
                n_s6_clip = n_s6_clip | sa[W] | (r_s5_capped & r_s5_enz[i]);
            end
            if (!r_s5_pin[1]) begin
                n_s6_data[(3+i)*W +: W] = sb[W-1:0];
                n_s6_clip = n_s6_clip | sb[W] | (r_s5_capped & r_s5_enz[i]);
            end
        end
        if (r_s5_zero) begin
            n_s6_data = '0;
            n_s6_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_s_tvalid;
            r_s1_v <= div_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_e[i]    <= div_e[i];
                r_s1_prod[i] <= n_s1_prod[i];
                r_s2_e[i]    <= r_s1_e[i];
                r_s3_e[i]    <= r_s2_e[i];
                r_s4_e[i]    <= r_s3_e[i];
                r_s5_m[i]    <= n_s5_m[i];
                r_s5_rneg[i] <= r_s4_fneg ^ r_s4_e[i][EW-1];
                r_s5_enz[i]  <= (r_s4_e[i] != '0);
            end
            r_s1_stretch <= n_s1_stretch;
            r_s1_pin     <= div_side[3*W+1:3*W];
            r_s1_zero    <= div_side[3*W+2];

            r_s2_speed   <= n_s2_speed;
            r_s2_stretch <= r_s1_stretch;
            r_s2_pin     <= r_s1_pin;
            r_s2_zero    <= r_s1_zero;

            r_s3_sp_mag  <= n_s3_sp_mag;
            r_s3_dm_mag  <= n_s3_dm_mag;
            r_s3_sp_neg  <= r_s2_stretch[SW-1];
            r_s3_dm_neg  <= r_s2_speed[SPW-1];
            r_s3_hit     <= n_s3_hit;
            r_s3_pin     <= r_s2_pin;
            r_s3_zero    <= r_s2_zero;

            r_s4_fmag    <= n_s4_fmag;
            r_s4_fneg    <= n_s4_fneg;
            r_s4_capped  <= r_s3_hit | n_s4_over;
            r_s4_pin     <= r_s3_pin;
            r_s4_zero    <= r_s3_zero;

            r_s5_capped  <= r_s4_capped;
            r_s5_pin     <= r_s4_pin;
            r_s5_zero    <= r_s4_zero;

            r_s6_data    <= n_s6_data;
            r_s6_user    <= {n_s6_clip, r_s5_zero};
        end
    end

    assign o_m_tvalid = r_s6_v;
    assign o_m_tdata  = r_s6_data;
    assign o_m_tuser  = r_s6_user;

`ifndef SYNTHESIS
    a_zero_len_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s6_v && r_s6_user[0] |-> (r_s6_data == '0) && !r_s6_user[1])
        else $error("zero-length result carries force or clip");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !r_s1_zero |->
            (r_s1_e[0] <= E_MAX) && (r_s1_e[0] >= -E_MAX) &&
            (r_s1_e[1] <= E_MAX) && (r_s1_e[1] >= -E_MAX) &&
            (r_s1_e[2] <= E_MAX) && (r_s1_e[2] >= -E_MAX))
        else $error("direction component exceeds one");

    a_force_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> r_s4_fmag <= CAP)
        else $error("scalar force above cap");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_s5_v == $past(r_s5_v) && r_s4_v == $past(r_s4_v))
        else $error("pipeline advanced during stall");
`endif

endmodule

>>> verif/sdf_checker.sv
`timescale 1ns / 1ps

module sdf_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [191:0] i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [191:0] i_m_tdata,
    input  logic [1:0]   i_m_tuser,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending,
    output int           o_results
);
    import sdf_pkg::*;

    localparam logic [63:0] FORCE_LIMIT = 64'd1 << 47;

    typedef struct packed {
        logic [191:0] forces;
        logic [1:0]   flags;
    } t_force_result;

    logic [30:0] stiffness;
    logic [30:0] damping;
    logic [30:0] rest_len;
    t_force_result expected_forces[$];

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // scale by a gain, capping the magnitude at the force limit
    function automatic longint gain_term(input logic [30:0] gain, input longint x,
                                         inout bit hit);
        logic [63:0] m;
        logic [95:0] p;
        m = mag64(x);
        p = {65'd0, gain} * {32'd0, m};
        p = p >> 16;
        if (p > {32'd0, FORCE_LIMIT}) begin
            hit = 1;
            p = {32'd0, FORCE_LIMIT};
        end
        return (x < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic [31:0] sat_word(input longint r, inout bit clip);
        if (r > 64'sd2147483647) begin
            clip = 1;
            return 32'h7fffffff;
        end
        if (r < -64'sd2147483648) begin
            clip = 1;
            return 32'h80000000;
        end
        return r[31:0];
    endfunction

    function automatic t_force_result predict_forces(input logic [191:0] data,
                                                     input logic [1:0] pins);
        t_force_result res;
        longint sep[3], vel[3], dir[3], rr;
        logic [63:0] sq, sep_len, fmag, m;
        longint dot, speed, stretch, f;
        bit capped, clip;
        capped = 0;
        clip = 0;
        sq = 0;
        dot = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            sep[i] = longint'($signed(data[32*i +: 32]));
            vel[i] = longint'($signed(data[32*(i+3) +: 32]));
            sq = sq + mag64(sep[i]) * mag64(sep[i]);
        end
        if (sq == 0) begin
            res.flags = 2'b01;
            return res;
        end
        sep_len = isqrt64(sq);
        for (int i = 0; i < 3; i++) begin
            dir[i] = (sep[i] * 65536) / longint'(sep_len);
            dot = dot + vel[i] * dir[i];
        end
        speed = dot / 65536;
        stretch = longint'(sep_len) - longint'({33'd0, rest_len});
        f = -(gain_term(stiffness, stretch, capped) + gain_term(damping, speed, capped));
        if (f > longint'(FORCE_LIMIT)) begin
            f = longint'(FORCE_LIMIT);
            capped = 1;
        end else if (f < -longint'(FORCE_LIMIT)) begin
            f = -longint'(FORCE_LIMIT);
            capped = 1;
        end
        fmag = mag64(f);
        for (int i = 0; i < 3; i++) begin
            m = (fmag * mag64(dir[i])) >> 16;
            rr = ((f < 0) != (dir[i] < 0)) ? -longint'(m) : longint'(m);
            if (!pins[0]) begin
                res.forces[32*i +: 32] = sat_word(rr, clip);
                if (capped && dir[i] != 0) clip = 1;
            end
            if (!pins[1]) begin
                res.forces[32*(i+3) +: 32] = sat_word(-rr, clip);
                if (capped && dir[i] != 0) clip = 1;
            end
        end
        res.flags = {clip, 1'b0};
        return res;
    endfunction

    assign o_pending = expected_forces.size();

    always @(posedge i_clk) begin
        t_force_result exp_r;
        if (!i_rst_n) begin
            stiffness <= 31'(STIFF_RESET_INT << 16);
            damping   <= 31'(DAMP_RESET_INT << 16);
            rest_len  <= 31'(REST_RESET_INT << 16);
            o_errors  <= 0;
            o_results <= 0;
            expected_forces.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_results <= o_results + 1;
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                             i_m_tdata, i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_forces.pop_front();
                    if (exp_r.forces !== i_m_tdata || exp_r.flags !== i_m_tuser) begin
                        $display("%0t: mismatch expected %h/%b actual %h/%b", $time,
                                 exp_r.forces, exp_r.flags, i_m_tdata, i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_forces.push_back(predict_forces(i_s_tdata, i_s_tuser));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STIFFNESS: stiffness <= i_cfg_data[30:0];
                    CFG_DAMPING:   damping   <= i_cfg_data[30:0];
                    CFG_REST:      rest_len  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sdf_pkg::*;

    localparam int LATENCY = 56;
    localparam int IDLE_LIMIT = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [191:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    int           fail_count;
    int           pending;
    int           result_count;
    int           idle_cycles;
    bit           hold_sink;
    bit           sink_random;
    int           sent;

    spring_damper_force_core u_dut (.*);

    sdf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(fail_count), .o_pending(pending), .o_results(result_count)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [31:0] rand_word(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 262143)) - 131072);
            2: return 32'($signed($urandom_range(0, 8388607)) - 4194304);
            default: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom())};
        endcase
    endfunction

    // receiver: random stalls, or a long hold while the pipe fills
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink)
            i_m_tready <= 1'b0;
        else if (!sink_random)
            i_m_tready <= 1'b1;
        else
            i_m_tready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || i_cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input logic [191:0] data, input logic [1:0] pins);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk) i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= pins;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_pipe();
        @(negedge i_clk) i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int count, input int mode);
        for (int n = 0; n < count; n++) begin
            logic [191:0] data;
            int m;
            for (int j = 0; j < 6; j++) begin
                m = (mode < 0) ? $urandom_range(0, 3) : mode;
                data[32*j +: 32] = rand_word(m);
            end
            if ($urandom_range(0, 15) == 0) data[95:0] = '0;
            send_item(data, 2'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        logic [191:0] d;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_STIFFNESS;
        i_cfg_data = '0;
        i_m_tready = 0;
        hold_sink = 0;
        sink_random = 0;
        sent = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: zero separation, pinning, extremes, rest length, velocity
        send_item('0, 2'b00);
        d = '0; d[31:0] = 32'h0001_0000; send_item(d, 2'b00);
        d = '0; d[31:0] = 32'h0003_0000; d[127:96] = 32'hfffe_0000; send_item(d, 2'b00);
        d = '0; d[63:32] = 32'hfffd_0000; d[159:128] = 32'h0002_0000; send_item(d, 2'b01);
        d = '0; d[95:64] = 32'h0000_8000; d[191:160] = 32'h7fff_ffff; send_item(d, 2'b10);
        d = '0; d[31:0] = 32'h0002_0000; send_item(d, 2'b11);
        d = {6{32'h7fff_ffff}}; send_item(d, 2'b00);
        d = {6{32'h8000_0000}}; send_item(d, 2'b00);
        d = {96'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}; send_item(d, 2'b00);
        d = '0; d[31:0] = 32'h0000_0001; send_item(d, 2'b00);
        d = '0; d[31:0] = 32'hffff_ffff; d[63:32] = 32'h0000_0001; send_item(d, 2'b00);
        d = {32'hffff_ffff, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0001_0000};
        send_item(d, 2'b00);
        d = {32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_8000}; send_item(d, 2'b00);
        random_items(6, 1);
        drain_pipe();

        // extreme configuration: all-ones data, upper bit must be ignored
        write_reg(CFG_STIFFNESS, 32'hffff_ffff);
        write_reg(CFG_DAMPING, 32'hffff_ffff);
        write_reg(CFG_REST, 32'hffff_ffff);
        write_reg(2'd3, 32'h1234_5678);
        sink_random = 1;
        random_items(100, -1);
        drain_pipe();

        write_reg(CFG_STIFFNESS, 32'h0);
        write_reg(CFG_DAMPING, 32'h0);
        write_reg(CFG_REST, 32'h0);
        random_items(50, -1);
        drain_pipe();

        write_reg(CFG_STIFFNESS, $urandom_range(0, 32'h00ff_ffff));
        write_reg(CFG_DAMPING, $urandom_range(0, 32'h0010_0000));
        write_reg(CFG_REST, $urandom_range(0, 32'h0004_0000));
        // fill the pipe against a held receiver
        hold_sink = 1;
        fork
            random_items(90, 1);
            begin
                repeat (300) @(posedge i_clk);
                hold_sink = 0;
            end
        join
        // pause until every result is back
        drain_pipe();

        write_reg(CFG_STIFFNESS, 32'h0280_0000);
        write_reg(CFG_DAMPING, 32'h000d_0000);
        write_reg(CFG_REST, 32'h0001_0000);
        sink_random = 0;
        random_items(60, 2);
        sink_random = 1;
        random_items(130, -1);
        drain_pipe();

        $display("Sent %0d spring items over five register settings; %0d results checked.",
                 sent, result_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
